// ===== hw/rtl/fsfp_pkg.sv =====
`default_nettype none

package fsfp_pkg;

    localparam int STAMP_W = 48;
    localparam int CFG_W   = 24;
    localparam int IDX_W   = 2;

    localparam logic [IDX_W-1:0] CFG_IDX_MODE      = 2'd0;
    localparam logic [IDX_W-1:0] CFG_IDX_INTERVAL  = 2'd1;
    localparam logic [IDX_W-1:0] CFG_IDX_THRESHOLD = 2'd2;

    localparam logic             MODE_RESET      = 1'b0;
    localparam logic [CFG_W-1:0] INTERVAL_RESET  = 24'd33333;
    localparam logic [CFG_W-1:0] THRESHOLD_RESET = 24'd150000;

    typedef enum logic [1:0] {
        KIND_INTER   = 2'd0,
        KIND_NORMAL  = 2'd1,
        KIND_DROPPED = 2'd2,
        KIND_JUMPED  = 2'd3
    } kind_t;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_sel_el;
        logic capture_el;
        logic commit;
    } fsfp_cmd_t;

    typedef struct packed {
        logic  variable_mode;
        kind_t kind;
        logic  div_done;
        logic  out_free;
    } fsfp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fixed_step_frame_pacer.sv =====
// Fixed-step frame pacer.
// Input channel s_*: one timestamp per transaction (microsecond ticks,
// nondecreasing). Result channel m_*: one frame record per input transaction,
// in order. Configuration channel cfg_*: index 0 tick mode, 1 frame interval,
// 2 jump threshold; always ready, write only while no transaction is in flight.
// Variable mode, intermediate and dropped steps go from the input register to
// the result register without the divider; a normal frame first runs the
// bit-serial divider (one quotient bit per cycle) on the timestamp, and a
// jumped frame runs it on the elapsed time and then on the timestamp. A new
// timestamp is taken only after the previous result is loaded, so the block
// finishes one item before it accepts the next.
// Reset clears the frame time, last timestamp, both counters and the seeded
// flag, and restores the register defaults (fixed mode, 33333, 150000).
// The result register holds one record; while the receiver stalls the block
// finishes the next item and then waits with s_ready low until the held
// record is taken.
`default_nettype none

module fixed_step_frame_pacer
    import fsfp_pkg::*;
#(
    parameter int TIME_BITS = 48
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [STAMP_W-1:0] s_timestamp,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_frame_kind,
    output logic                    m_frame_tick,
    output logic [STAMP_W-1:0]      m_frame_count,
    output logic [STAMP_W-1:0]      m_frame_stamp,
    output logic [STAMP_W-1:0]      m_frame_step,
    output logic [STAMP_W-1:0]      m_cycle_step,
    output logic [STAMP_W-1:0]      m_cycle_count,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_data
);

    logic             tick_mode_reg;
    logic [CFG_W-1:0] frame_interval_reg;
    logic [CFG_W-1:0] jump_threshold_reg;

    fsfp_cmd_t    cmd;
    fsfp_status_t status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_mode_reg      <= MODE_RESET;
            frame_interval_reg <= INTERVAL_RESET;
            jump_threshold_reg <= THRESHOLD_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_IDX_MODE:      tick_mode_reg      <= cfg_data[0];
                CFG_IDX_INTERVAL:  frame_interval_reg <= cfg_data;
                CFG_IDX_THRESHOLD: jump_threshold_reg <= cfg_data;
                default: begin
                    tick_mode_reg <= tick_mode_reg;
                end
            endcase
        end
    end

    fsfp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    fsfp_dp #(
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .tick_mode      (tick_mode_reg),
        .frame_interval (frame_interval_reg),
        .jump_threshold (jump_threshold_reg),
        .s_timestamp    (s_timestamp),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_frame_kind   (m_frame_kind),
        .m_frame_tick   (m_frame_tick),
        .m_frame_count  (m_frame_count),
        .m_frame_stamp  (m_frame_stamp),
        .m_frame_step   (m_frame_step),
        .m_cycle_step   (m_cycle_step),
        .m_cycle_count  (m_cycle_count)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/fsfp_div.sv =====
`default_nettype none

module fsfp_div
    import fsfp_pkg::*;
#(
    parameter int TIME_BITS = 48
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic [TIME_BITS-1:0] dividend,
    input  wire logic [CFG_W-1:0]     divisor,
    output logic                      done,
    output logic [TIME_BITS-1:0]      quotient,
    output logic [CFG_W-1:0]          remainder
);

    localparam int CNT_W = $clog2(TIME_BITS);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [TIME_BITS-1:0] quo_reg;
    logic [CFG_W-1:0]     rem_reg;
    logic [CFG_W-1:0]     dsr_reg;

    logic [CFG_W:0]       shifted;
    logic                 fits;

    assign shifted = {rem_reg, quo_reg[TIME_BITS-1]};
    assign fits    = shifted >= {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                if (cnt_reg == CNT_W'(TIME_BITS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[TIME_BITS-2:0], fits};
            rem_reg <= fits ? CFG_W'(shifted - {1'b0, dsr_reg}) : shifted[CFG_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/fsfp_ctrl.sv =====
`default_nettype none

module fsfp_ctrl
    import fsfp_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire fsfp_status_t  status,
    output fsfp_cmd_t          cmd
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CLASS  = 5'b00010,
        ST_DIV_EL = 5'b00100,
        ST_DIV_TS = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CLASS;
                end
            end
            ST_CLASS: begin
                if (status.variable_mode || status.kind == KIND_INTER
                    || status.kind == KIND_DROPPED) begin
                    state_next = ST_DONE;
                end else if (status.kind == KIND_NORMAL) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV_TS;
                end else begin
                    cmd.div_start  = 1'b1;
                    cmd.div_sel_el = 1'b1;
                    state_next     = ST_DIV_EL;
                end
            end
            ST_DIV_EL: begin
                if (status.div_done) begin
                    cmd.capture_el = 1'b1;
                    cmd.div_start  = 1'b1;
                    state_next     = ST_DIV_TS;
                end
            end
            ST_DIV_TS: begin
                if (status.div_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule

`default_nettype wire

// ===== hw/rtl/fsfp_dp.sv =====
`default_nettype none

module fsfp_dp
    import fsfp_pkg::*;
#(
    parameter int TIME_BITS = 48
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire fsfp_cmd_t          cmd,
    output fsfp_status_t            status,
    input  wire logic               tick_mode,
    input  wire logic [CFG_W-1:0]   frame_interval,
    input  wire logic [CFG_W-1:0]   jump_threshold,
    input  wire logic [STAMP_W-1:0] s_timestamp,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_frame_kind,
    output logic                    m_frame_tick,
    output logic [STAMP_W-1:0]      m_frame_count,
    output logic [STAMP_W-1:0]      m_frame_stamp,
    output logic [STAMP_W-1:0]      m_frame_step,
    output logic [STAMP_W-1:0]      m_cycle_step,
    output logic [STAMP_W-1:0]      m_cycle_count
);

    localparam int T = TIME_BITS;

    logic [T-1:0] ts_reg;
    logic [T-1:0] cstep_reg;
    logic [T-1:0] el_reg;
    logic [T-1:0] lfs_reg;
    logic [T-1:0] seen_reg;
    logic         seeded_reg;
    logic [T-1:0] fc_reg;
    logic [T-1:0] cc_reg;
    logic [T-1:0] cnt_reg;
    logic [T-1:0] fstep_j_reg;
    logic         m_valid_reg;

    logic [T-1:0] ts_in;
    logic [T-1:0] base;
    logic [T-1:0] cstep_next;
    logic [T-1:0] el_next;
    logic [CFG_W-1:0] iv24;
    logic [T-1:0] iv_w;
    logic [T-1:0] rem_w;
    kind_t        kind;

    logic         div_done;
    logic [T-1:0] div_quo;
    logic [CFG_W-1:0] div_rem;
    logic [T-1:0] div_rem_w;

    logic [T-1:0] fc_next;
    logic [T-1:0] fstamp;
    logic [T-1:0] fstep;
    logic [T-1:0] lfs_next;
    kind_t        kind_out;

    assign ts_in      = T'(s_timestamp);
    assign base       = seeded_reg ? seen_reg : ts_in;
    assign cstep_next = (ts_in >= base) ? ts_in - base : '0;
    assign el_next    = (ts_in >= lfs_reg) ? ts_in - lfs_reg : '0;

    assign iv24  = (frame_interval == '0) ? CFG_W'(1) : frame_interval;
    assign iv_w  = T'(iv24);
    assign rem_w = el_reg - iv_w;

    always_comb begin
        if (el_reg < iv_w) begin
            kind = KIND_INTER;
        end else if (rem_w < iv_w) begin
            kind = KIND_NORMAL;
        end else if (rem_w > T'(jump_threshold)) begin
            kind = KIND_JUMPED;
        end else begin
            kind = KIND_DROPPED;
        end
    end

    fsfp_div #(
        .TIME_BITS (T)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (cmd.div_sel_el ? el_reg : ts_reg),
        .divisor   (iv24),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign div_rem_w = T'(div_rem);

    assign status.variable_mode = tick_mode;
    assign status.kind          = kind;
    assign status.div_done      = div_done;
    assign status.out_free      = !m_valid_reg || m_ready;

    always_comb begin
        fc_next  = fc_reg;
        fstamp   = lfs_reg;
        fstep    = el_reg;
        lfs_next = lfs_reg;
        kind_out = kind;
        if (tick_mode) begin
            kind_out = KIND_NORMAL;
            fc_next  = fc_reg + 1'b1;
            fstamp   = ts_reg;
            fstep    = cstep_reg;
        end else begin
            case (kind)
                KIND_INTER: begin
                    fstamp = lfs_reg;
                    fstep  = el_reg;
                end
                KIND_NORMAL: begin
                    fc_next  = fc_reg + 1'b1;
                    fstep    = iv_w;
                    fstamp   = lfs_reg + iv_w;
                    lfs_next = ts_reg - div_rem_w;
                end
                KIND_DROPPED: begin
                    fc_next  = fc_reg + 1'b1;
                    fstep    = iv_w;
                    fstamp   = lfs_reg + iv_w;
                    lfs_next = lfs_reg + iv_w;
                end
                KIND_JUMPED: begin
                    fc_next  = fc_reg + 1'b1 + cnt_reg;
                    fstep    = fstep_j_reg;
                    fstamp   = lfs_reg + fstep_j_reg;
                    lfs_next = ts_reg - div_rem_w;
                end
                default: begin
                    fc_next = fc_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ts_reg    <= ts_in;
            cstep_reg <= cstep_next;
            el_reg    <= el_next;
        end
        if (cmd.capture_el) begin
            cnt_reg     <= div_quo + T'(div_rem != '0);
            fstep_j_reg <= el_reg + ((div_rem != '0) ? iv_w - div_rem_w : '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lfs_reg    <= '0;
            seen_reg   <= '0;
            seeded_reg <= 1'b0;
            fc_reg     <= '0;
            cc_reg     <= '0;
        end else begin
            if (cmd.load) begin
                seen_reg   <= ts_in;
                seeded_reg <= 1'b1;
                cc_reg     <= cc_reg + 1'b1;
            end
            if (cmd.commit) begin
                fc_reg  <= fc_next;
                lfs_reg <= lfs_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_frame_kind  <= kind_out;
            m_frame_tick  <= (kind_out != KIND_INTER);
            m_frame_count <= STAMP_W'(fc_next);
            m_frame_stamp <= STAMP_W'(fstamp);
            m_frame_step  <= STAMP_W'(fstep);
            m_cycle_step  <= STAMP_W'(cstep_reg);
            m_cycle_count <= STAMP_W'(cc_reg);
        end
    end

    assign m_valid = m_valid_reg;

    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_valid_reg || m_ready))
        else $error("result overwritten before it was taken");

    a_commit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_valid_reg)
        else $error("committed result not presented");

    a_tick_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_frame_tick == (m_frame_kind != KIND_INTER)))
        else $error("frame tick disagrees with frame kind");

endmodule

`default_nettype wire

// ===== dv/tb_fixed_step_frame_pacer.sv =====
`default_nettype none

module tb_fixed_step_frame_pacer;
    import fsfp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 2 * STAMP_W + 8;
    localparam int STALL_LIMIT   = 2000;
    localparam int PRESSURE_HOLD = 400;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 200;

    typedef logic [STAMP_W-1:0] stamp_t;

    typedef struct packed {
        kind_t  kind;
        logic   tick;
        stamp_t count;
        stamp_t stamp;
        stamp_t fstep;
        stamp_t cstep;
        stamp_t ccount;
    } frame_rec_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [STAMP_W-1:0] s_timestamp;
    logic               m_valid;
    logic               m_ready;
    logic [1:0]         m_frame_kind;
    logic               m_frame_tick;
    logic [STAMP_W-1:0] m_frame_count;
    logic [STAMP_W-1:0] m_frame_stamp;
    logic [STAMP_W-1:0] m_frame_step;
    logic [STAMP_W-1:0] m_cycle_step;
    logic [STAMP_W-1:0] m_cycle_count;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]   cfg_data;

    // pacer state as the block should hold it
    logic       mode_q;
    logic [CFG_W-1:0] interval_q;
    logic [CFG_W-1:0] thresh_q;
    stamp_t     frame_q;
    stamp_t     seen_q;
    stamp_t     frames_q;
    stamp_t     cycles_q;
    logic       seeded_q;

    frame_rec_t frame_due[$];
    stamp_t     cur_stamp;
    int         errors;
    int         stamps_sent;
    int         records_checked;
    int         settings_used;
    int         kind_hits[4];
    logic       src_gaps_on;
    logic       sink_gaps_on;
    int         hold_request;
    int         quiet_cycles = 0;

    fixed_step_frame_pacer i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_timestamp   (s_timestamp),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_frame_kind  (m_frame_kind),
        .m_frame_tick  (m_frame_tick),
        .m_frame_count (m_frame_count),
        .m_frame_stamp (m_frame_stamp),
        .m_frame_step  (m_frame_step),
        .m_cycle_step  (m_cycle_step),
        .m_cycle_count (m_cycle_count),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic frame_rec_t pace_step(input stamp_t ts);
        frame_rec_t r;
        stamp_t     iv;
        stamp_t     el;
        stamp_t     rem;
        stamp_t     jumps;
        iv = (interval_q == '0) ? stamp_t'(1) : stamp_t'(interval_q);
        if (!seeded_q) begin
            seen_q   = ts;
            seeded_q = 1'b1;
        end
        r.cstep  = (ts >= seen_q) ? ts - seen_q : '0;
        seen_q   = ts;
        cycles_q = cycles_q + 1;
        if (mode_q) begin
            r.kind   = KIND_NORMAL;
            frames_q = frames_q + 1;
            r.stamp  = ts;
            r.fstep  = r.cstep;
        end else begin
            el = (ts >= frame_q) ? ts - frame_q : '0;
            if (el < iv) begin
                r.kind  = KIND_INTER;
                r.stamp = frame_q;
                r.fstep = el;
            end else begin
                rem = el - iv;
                if (rem < iv) begin
                    r.kind   = KIND_NORMAL;
                    frames_q = frames_q + 1;
                    r.fstep  = iv;
                    r.stamp  = frame_q + iv;
                    frame_q  = ts - (ts % iv);
                end else if (rem > stamp_t'(thresh_q)) begin
                    jumps    = el / iv + stamp_t'((el % iv) != '0);
                    r.kind   = KIND_JUMPED;
                    frames_q = frames_q + 1 + jumps;
                    r.fstep  = jumps * iv;
                    r.stamp  = frame_q + r.fstep;
                    frame_q  = ts - (ts % iv);
                end else begin
                    r.kind   = KIND_DROPPED;
                    frames_q = frames_q + 1;
                    r.fstep  = iv;
                    r.stamp  = frame_q + iv;
                    frame_q  = r.stamp;
                end
            end
        end
        r.tick   = (r.kind != KIND_INTER);
        r.count  = frames_q;
        r.ccount = cycles_q;
        kind_hits[r.kind]++;
        return r;
    endfunction

    function automatic stamp_t next_stamp();
        int unsigned span;
        int unsigned pick;
        span = (interval_q == '0) ? 1 : int'(interval_q);
        pick = $urandom_range(0, 99);
        if (pick < 60)
            cur_stamp = cur_stamp + $urandom_range(0, 2 * span);
        else if (pick < 75)
            cur_stamp = cur_stamp + stamp_t'(span) * $urandom_range(2, 8)
                        + $urandom_range(0, span - 1);
        else if (pick < 85)
            cur_stamp = cur_stamp + thresh_q + span + $urandom_range(0, 4 * span);
        else if (pick < 90)
            cur_stamp = cur_stamp - $urandom_range(0, 2 * span);
        else if (pick >= 95)
            cur_stamp = stamp_t'({$urandom, $urandom});
        return cur_stamp;
    endfunction

    task automatic push_stamp(input stamp_t ts);
        int gap;
        gap = src_gaps_on ? $urandom_range(0, 6) : 0;
        @(negedge aclk);
        repeat (gap) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid     = 1'b1;
        s_timestamp = ts;
        do @(posedge aclk); while (s_ready !== 1'b1);
        frame_due.push_back(pace_step(ts));
        stamps_sent++;
    endtask

    task automatic settle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (frame_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        case (idx)
            CFG_IDX_MODE:      mode_q     = data[0];
            CFG_IDX_INTERVAL:  interval_q = data;
            CFG_IDX_THRESHOLD: thresh_q   = data;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic apply_setting(input logic mode, input logic [CFG_W-1:0] iv,
                                 input logic [CFG_W-1:0] thr);
        write_reg(CFG_IDX_MODE, CFG_W'(mode));
        write_reg(CFG_IDX_INTERVAL, iv);
        write_reg(CFG_IDX_THRESHOLD, thr);
        settings_used++;
    endtask

    task automatic check_field(input string name, input stamp_t want, input stamp_t got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
        end
    endtask

    task automatic test_default_steps();
        src_gaps_on  = 1'b1;
        sink_gaps_on = 1'b1;
        push_stamp(48'd1000);
        push_stamp(48'd1000);
        push_stamp(48'd20000);
        push_stamp(48'd33333);
        push_stamp(48'd50000);
        push_stamp(48'd66666);
        push_stamp(48'd146666);
        push_stamp(48'd600000);
        push_stamp(48'd599000);
        push_stamp(48'd0);
        push_stamp('1);
        push_stamp(48'd0);
        settle();
    endtask

    task automatic test_interval_extremes();
        apply_setting(1'b0, '0, '0);
        push_stamp(48'd5);
        push_stamp(48'd6);
        push_stamp(48'd8);
        push_stamp(48'd100);
        settle();
        apply_setting(1'b0, '1, '1);
        push_stamp(48'd50331645);
        push_stamp(48'd50331650);
        push_stamp(48'd335544300);
        push_stamp('1);
        settle();
    endtask

    task automatic test_variable_mode();
        apply_setting(1'b1, INTERVAL_RESET, THRESHOLD_RESET);
        push_stamp(48'd10);
        push_stamp(48'd10);
        push_stamp(48'd5);
        push_stamp(48'd1000);
        push_stamp('1);
        settle();
        apply_setting(MODE_RESET, INTERVAL_RESET, THRESHOLD_RESET);
        cur_stamp = 48'd1000;
    endtask

    task automatic test_backpressure();
        src_gaps_on  = 1'b0;
        hold_request = PRESSURE_HOLD;
        repeat (30) push_stamp(next_stamp());
        settle();
        src_gaps_on = 1'b1;
    endtask

    task automatic test_random_phases();
        logic [CFG_W-1:0] iv;
        logic [CFG_W-1:0] thr;
        logic             mode;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            mode = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 6))
                0: iv = '0;
                1: iv = CFG_W'(1);
                2: iv = CFG_W'($urandom_range(2, 50));
                3: iv = CFG_W'($urandom_range(100, 100000));
                4: iv = INTERVAL_RESET;
                5: iv = '1;
                default: iv = CFG_W'($urandom);
            endcase
            case ($urandom_range(0, 3))
                0: thr = '0;
                1: thr = '1;
                2: thr = CFG_W'($urandom_range(0, 4 * ((iv == '0) ? 1 : int'(iv))));
                default: thr = CFG_W'($urandom);
            endcase
            apply_setting(mode, iv, thr);
            src_gaps_on  = ($urandom_range(0, 3) != 0);
            sink_gaps_on = ($urandom_range(0, 3) != 0);
            repeat (PHASE_ITEMS) push_stamp(next_stamp());
            settle();
        end
    endtask

    initial begin : result_sink
        int         gap;
        int         hold;
        frame_rec_t want;
        m_ready = 1'b0;
        gap     = 0;
        hold    = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_request > 0) begin
                hold         = hold_request;
                hold_request = 0;
            end
            if (hold > 0) begin
                m_ready = 1'b0;
                hold--;
            end else if (gap > 0) begin
                m_ready = 1'b0;
                gap--;
            end else begin
                m_ready = 1'b1;
            end
            @(posedge aclk);
            if (m_valid === 1'b1 && m_ready) begin
                gap = sink_gaps_on ? $urandom_range(0, 6) : 0;
                if (frame_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected frame record, expected none, got count %0d",
                             $realtime, m_frame_count);
                end else begin
                    want = frame_due.pop_front();
                    check_field("frame_kind", stamp_t'(want.kind), stamp_t'(m_frame_kind));
                    check_field("frame_tick", stamp_t'(want.tick), stamp_t'(m_frame_tick));
                    check_field("frame_count", want.count, m_frame_count);
                    check_field("frame_stamp", want.stamp, m_frame_stamp);
                    check_field("frame_step", want.fstep, m_frame_step);
                    check_field("cycle_step", want.cstep, m_cycle_step);
                    check_field("cycle_count", want.ccount, m_cycle_count);
                    records_checked++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d records outstanding",
                     $realtime, STALL_LIMIT, frame_due.size());
            $display("tb_fixed_step_frame_pacer: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_timestamp  = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_IDX_MODE;
        cfg_data     = '0;
        mode_q       = MODE_RESET;
        interval_q   = INTERVAL_RESET;
        thresh_q     = THRESHOLD_RESET;
        frame_q      = '0;
        seen_q       = '0;
        frames_q     = '0;
        cycles_q     = '0;
        seeded_q     = 1'b0;
        cur_stamp    = '0;
        errors       = 0;
        stamps_sent  = 0;
        records_checked = 0;
        settings_used = 1;
        kind_hits    = '{default: 0};
        src_gaps_on  = 1'b1;
        sink_gaps_on = 1'b1;
        hold_request = 0;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        test_default_steps();
        test_interval_extremes();
        test_variable_mode();
        test_backpressure();
        test_random_phases();

        settle();
        if (frame_due.size() != 0) begin
            errors++;
            $display("%0t: %0d frame records never arrived", $realtime, frame_due.size());
        end
        $display("checked %0d of %0d timestamps across %0d register settings", records_checked,
                 stamps_sent, settings_used);
        $display("kinds: %0d intermediate, %0d normal, %0d dropped, %0d jumped",
                 kind_hits[KIND_INTER], kind_hits[KIND_NORMAL], kind_hits[KIND_DROPPED],
                 kind_hits[KIND_JUMPED]);
        if (errors == 0) begin
            $display("tb_fixed_step_frame_pacer: clean");
        end else begin
            $display("tb_fixed_step_frame_pacer: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
